[design/itp_pkg.sv]
`default_nettype none
package itp_pkg;

	localparam int STACK_DEPTH_DEF = 16;

	localparam logic [7:0] CH_LP  = 8'h28;
	localparam logic [7:0] CH_RP  = 8'h29;
	localparam logic [7:0] CH_ADD = 8'h2B;
	localparam logic [7:0] CH_SUB = 8'h2D;
	localparam logic [7:0] CH_MUL = 8'h2A;
	localparam logic [7:0] CH_DIV = 8'h2F;
	localparam logic [7:0] CH_MOD = 8'h25;
	localparam logic [7:0] CH_POW = 8'h5E;

	typedef enum logic [2:0] {
		OP_LP   = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4,
		OP_MOD  = 3'd5,
		OP_POW  = 3'd6,
		OP_NONE = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		CL_OPND = 3'd0,
		CL_LP   = 3'd1,
		CL_RP   = 3'd2,
		CL_OP   = 3'd3,
		CL_END  = 3'd4
	} cls_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_OVF = 2'd1,
		ST_UNM = 2'd2
	} st_t;

	typedef struct packed {
		logic latch;
		logic push;
		logic pop;
		logic set_ovf;
		logic set_unm;
		logic clr_flags;
		logic emit_in;
		logic emit_top;
		logic emit_end;
	} cmd_t;

	typedef struct packed {
		cls_t cls;
		logic empty;
		logic full;
		logic top_lp;
		logic top_ge;
		logic out_free;
	} sts_t;

	function automatic op_t code_of(input logic [7:0] c);
		op_t r;
		case (c)
			CH_LP:   r = OP_LP;
			CH_ADD:  r = OP_ADD;
			CH_SUB:  r = OP_SUB;
			CH_MUL:  r = OP_MUL;
			CH_DIV:  r = OP_DIV;
			CH_MOD:  r = OP_MOD;
			CH_POW:  r = OP_POW;
			default: r = OP_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] op_char(input op_t op);
		logic [7:0] r;
		case (op)
			OP_LP:   r = CH_LP;
			OP_ADD:  r = CH_ADD;
			OP_SUB:  r = CH_SUB;
			OP_MUL:  r = CH_MUL;
			OP_DIV:  r = CH_DIV;
			OP_MOD:  r = CH_MOD;
			OP_POW:  r = CH_POW;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] op_prio(input op_t op);
		logic [2:0] r;
		case (op)
			OP_LP:                  r = 3'd2;
			OP_ADD, OP_SUB:         r = 3'd3;
			OP_MUL, OP_DIV, OP_MOD: r = 3'd4;
			OP_POW:                 r = 3'd5;
			default:                r = 3'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[design/itp_ctrl.sv]
`default_nettype none
module itp_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire itp_pkg::sts_t sts,
	output itp_pkg::cmd_t      cmd
);
	import itp_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_RUN;
				end
			end
			S_RUN: begin
				case (sts.cls)
					CL_OPND: begin
						if (sts.out_free) begin
							cmd.emit_in = 1'b1;
							state_d     = S_IDLE;
						end
					end
					CL_LP: begin
						if (sts.full) cmd.set_ovf = 1'b1;
						else cmd.push = 1'b1;
						state_d = S_IDLE;
					end
					CL_OP: begin
						if (!sts.empty && sts.top_ge) begin
							if (sts.out_free) begin
								cmd.pop      = 1'b1;
								cmd.emit_top = 1'b1;
							end
						end else begin
							if (sts.full) cmd.set_ovf = 1'b1;
							else cmd.push = 1'b1;
							state_d = S_IDLE;
						end
					end
					CL_RP: begin
						if (sts.empty) begin
							cmd.set_unm = 1'b1;
							state_d     = S_IDLE;
						end else if (sts.top_lp) begin
							cmd.pop = 1'b1;
							state_d = S_IDLE;
						end else if (sts.out_free) begin
							cmd.pop      = 1'b1;
							cmd.emit_top = 1'b1;
						end
					end
					CL_END: begin
						if (!sts.empty) begin
							if (sts.top_lp) begin
								cmd.pop = 1'b1;
							end else if (sts.out_free) begin
								cmd.pop      = 1'b1;
								cmd.emit_top = 1'b1;
							end
						end else if (sts.out_free) begin
							cmd.emit_end  = 1'b1;
							cmd.clr_flags = 1'b1;
							state_d       = S_IDLE;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule
`default_nettype wire

[design/itp_dp.sv]
`default_nettype none
module itp_dp #(
	parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          kind,
	input  wire logic [7:0]    symbol,
	input  wire itp_pkg::cmd_t cmd,
	output itp_pkg::sts_t      sts,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [7:0]         out_symbol,
	output logic               end_mark,
	output logic [1:0]         status
);
	import itp_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [2:0]    mem [STACK_DEPTH];
	logic [CW-1:0] cnt_q, cnt_d, cnt_m1;
	logic [AW-1:0] rd_addr;
	op_t           top_q;
	logic          kind_q;
	logic [7:0]    sym_q;
	op_t           code;
	logic [1:0]    flags_q;
	st_t           st;
	logic          out_valid_q;
	logic [7:0]    out_sym_q;
	logic          out_end_q;
	logic [1:0]    out_st_q;

	assign code = code_of(sym_q);

	always_comb begin
		sts          = '0;
		if (kind_q) sts.cls = CL_END;
		else if (sym_q == CH_RP) sts.cls = CL_RP;
		else if (code == OP_NONE) sts.cls = CL_OPND;
		else if (code == OP_LP) sts.cls = CL_LP;
		else sts.cls = CL_OP;
		sts.empty    = (cnt_q == '0);
		sts.full     = (cnt_q == CW'(STACK_DEPTH));
		sts.top_lp   = (top_q == OP_LP);
		sts.top_ge   = (op_prio(top_q) >= op_prio(code));
		sts.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q <= kind;
			sym_q  <= symbol;
		end
	end

	// top of stack kept in a register; read port follows the next count
	always_comb begin
		cnt_d = cnt_q;
		if (cmd.push) cnt_d = cnt_q + CW'(1);
		else if (cmd.pop) cnt_d = cnt_q - CW'(1);
		cnt_m1  = cnt_d - CW'(1);
		rd_addr = cnt_m1[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.push) mem[cnt_q[AW-1:0]] <= code;
		if (cmd.push) top_q <= code;
		else top_q <= op_t'(mem[rd_addr]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			flags_q <= '0;
		end else begin
			cnt_q <= cnt_d;
			if (cmd.clr_flags) flags_q <= '0;
			else flags_q <= flags_q | {cmd.set_unm, cmd.set_ovf};
		end
	end

	always_comb begin
		if (flags_q[0]) st = ST_OVF;
		else if (flags_q[1]) st = ST_UNM;
		else st = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.emit_in || cmd.emit_top || cmd.emit_end) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_in) begin
			out_sym_q <= sym_q;
			out_end_q <= 1'b0;
			out_st_q  <= ST_OK;
		end else if (cmd.emit_top) begin
			out_sym_q <= op_char(top_q);
			out_end_q <= 1'b0;
			out_st_q  <= ST_OK;
		end else if (cmd.emit_end) begin
			out_sym_q <= 8'd0;
			out_end_q <= 1'b1;
			out_st_q  <= st;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_symbol = out_sym_q;
	assign end_mark   = out_end_q;
	assign status     = out_st_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count out of range");

	a_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && cmd.pop))
		else $error("push and pop together");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_in || cmd.emit_top || cmd.emit_end) |-> sts.out_free)
		else $error("emit into occupied output register");

	a_emit_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_in, cmd.emit_top, cmd.emit_end}))
		else $error("multiple emits");

	a_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_end |=> (flags_q == 2'b00) && (cnt_q == '0))
		else $error("state not cleared after end of expression");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !sts.full)
		else $error("push into full stack");

endmodule
`default_nettype wire

[design/infix_to_postfix_converter_core.sv]
// Infix to postfix converter (shunting-yard).
// Input channel (in_valid/in_ready): one transfer per infix character
// (kind = 0, symbol) or one end-of-expression item (kind = 1).
// Output channel (out_valid/out_ready): one transfer per postfix character;
// each expression ends with a transfer carrying end_mark = 1, out_symbol = 0
// and status (0 ok, 1 stack overflow, 2 unmatched close parenthesis).
// An item is accepted in S_IDLE and processed in S_RUN, which pops operators
// from the stack as it emits them: an operand is emitted, a ( is pushed, an
// operator is pushed once those of equal or higher priority are emitted, a )
// emits those above its ( and drops the (; an end item empties the stack.
// The stack has a single write port and a registered read port that tracks
// the next top entry, so the new top is in place in the cycle after a pop.
// A result appears at the output in the cycle after the cycle that produces it.
// When the receiver stalls, the output register holds its transfer and the
// controller waits on any step that needs to emit; in_ready stays low until
// the current item is finished.
// Reset clears the stack count, the error flags and the output valid; the
// stack storage itself is not cleared and needs no clearing pass.
`default_nettype none
module infix_to_postfix_converter_core #(
	parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       kind,
	input  wire logic [7:0] symbol,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_symbol,
	output logic            end_mark,
	output logic [1:0]      status
);
	import itp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	itp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	itp_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.kind       (kind),
		.symbol     (symbol),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_symbol (out_symbol),
		.end_mark   (end_mark),
		.status     (status)
	);

endmodule
`default_nettype wire
